// File: hw/rtl/ffs_pkg.sv
package ffs_pkg;

    localparam int GRAY_BITS     = 8;
    localparam int NUM_STEPS     = GRAY_BITS;
    localparam int EDGE_REF_BITS = 24;
    localparam int GRAY_SQ_BITS  = 16;
    localparam int SQ_HI_SHIFT   = 16;
    localparam int SQ_LO_SHIFT   = 9;

    localparam logic [GRAY_BITS-1:0] ALPHA_BYTE = 8'hFF;

    typedef struct packed {
        logic valid;
        logic active;
        logic deg;
    } ffs_ctl_t;

endpackage

// File: hw/rtl/flat_face_shading.sv
// a request taken with start gives its result, marked by done, once it has passed the stages below
// throughput: one triangle per cycle; busy stays low and the pipeline never stalls
// seven stages form edges, cross product, squares, norm and scaled z term,
// then eight stages each settle one gray bit by shift and add
// reset: asynchronous active low, clears the stage valid bits so no result is pending
module flat_face_shading #(
    parameter int COORD_BITS = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] v0_x,
    input  logic signed [COORD_BITS-1:0] v0_y,
    input  logic signed [COORD_BITS-1:0] v0_z,
    input  logic signed [COORD_BITS-1:0] v1_x,
    input  logic signed [COORD_BITS-1:0] v1_y,
    input  logic signed [COORD_BITS-1:0] v1_z,
    input  logic signed [COORD_BITS-1:0] v2_x,
    input  logic signed [COORD_BITS-1:0] v2_y,
    input  logic signed [COORD_BITS-1:0] v2_z,
    output logic                         done,
    output logic [7:0]                   gray_level,
    output logic [31:0]                  face_color,
    output logic                         degenerate
);

    localparam int EW  = (COORD_BITS > ffs_pkg::EDGE_REF_BITS) ?
                         ffs_pkg::EDGE_REF_BITS + 1 : COORD_BITS + 1;
    localparam int SH  = COORD_BITS + 1 - EW;
    localparam int PW  = 2 * EW;
    localparam int NW  = PW + 1;
    localparam int MW  = PW;
    localparam int LW  = MW / 2;
    localparam int HW  = MW - LW;
    localparam int SQW = 2 * MW;
    localparam int SW  = SQW + 2;
    localparam int RW  = SW + ffs_pkg::GRAY_SQ_BITS - 2;
    localparam int GW  = ffs_pkg::GRAY_BITS;
    localparam int GPW = SW + GW;
    localparam int QW  = SW + ffs_pkg::GRAY_SQ_BITS;
    localparam int NS  = ffs_pkg::NUM_STEPS;

    function automatic logic signed [EW-1:0] edge_of(
        input logic signed [COORD_BITS-1:0] hi,
        input logic signed [COORD_BITS-1:0] lo
    );
        logic signed [COORD_BITS:0] d;
        d = $signed({hi[COORD_BITS-1], hi}) - $signed({lo[COORD_BITS-1], lo});
        return EW'(d >>> SH);
    endfunction

    ffs_pkg::ffs_ctl_t ctl_next [1:7];
    ffs_pkg::ffs_ctl_t ctl_reg  [1:7];

    logic signed [EW-1:0]  edge_next [6];
    logic signed [EW-1:0]  edge_reg  [6];
    logic signed [PW-1:0]  prod_next [6];
    logic signed [PW-1:0]  prod_reg  [6];
    logic signed [NW-1:0]  cross_next[3];
    logic signed [NW-1:0]  cross_reg [3];
    logic [MW-1:0]         mag_next  [3];
    logic [MW-1:0]         mag_reg   [3];
    logic [2*HW-1:0]       hh_next   [3];
    logic [2*HW-1:0]       hh_reg    [3];
    logic [HW+LW-1:0]      hl_next   [3];
    logic [HW+LW-1:0]      hl_reg    [3];
    logic [2*LW-1:0]       ll_next   [3];
    logic [2*LW-1:0]       ll_reg    [3];
    logic [SQW-1:0]        sq_next   [3];
    logic [SQW-1:0]        sq_reg    [3];
    logic [SW-1:0]         s_next, s_reg;
    logic [RW-1:0]         r_next, r_reg;

    ffs_pkg::ffs_ctl_t     ctl_chain [NS+1];
    logic [GW-1:0]         g_chain   [NS+1];
    logic [GPW-1:0]        p_chain   [NS+1];
    logic [QW-1:0]         q_chain   [NS+1];
    logic [SW-1:0]         s_chain   [NS+1];
    logic [RW-1:0]         r_chain   [NS+1];

    assign busy = 1'b0;

    // edges, a = v1 - v0 and b = v2 - v0
    always_comb
    begin
        edge_next[0] = edge_of(v1_x, v0_x);
        edge_next[1] = edge_of(v1_y, v0_y);
        edge_next[2] = edge_of(v1_z, v0_z);
        edge_next[3] = edge_of(v2_x, v0_x);
        edge_next[4] = edge_of(v2_y, v0_y);
        edge_next[5] = edge_of(v2_z, v0_z);
    end

    // cross product terms
    always_comb
    begin
        prod_next[0] = PW'(edge_reg[1]) * PW'(edge_reg[5]);
        prod_next[1] = PW'(edge_reg[2]) * PW'(edge_reg[4]);
        prod_next[2] = PW'(edge_reg[2]) * PW'(edge_reg[3]);
        prod_next[3] = PW'(edge_reg[0]) * PW'(edge_reg[5]);
        prod_next[4] = PW'(edge_reg[0]) * PW'(edge_reg[4]);
        prod_next[5] = PW'(edge_reg[1]) * PW'(edge_reg[3]);
        for (int i = 0; i < 3; i++)
        begin
            cross_next[i] = NW'(prod_reg[2*i]) - NW'(prod_reg[2*i+1]);
        end
    end

    // magnitudes, split squares, squares, norm and 255^2 z^2
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_next[i] = cross_reg[i][NW-1] ? MW'(-cross_reg[i]) : MW'(cross_reg[i]);
            hh_next[i]  = mag_reg[i][MW-1:LW] * mag_reg[i][MW-1:LW];
            hl_next[i]  = mag_reg[i][MW-1:LW] * mag_reg[i][LW-1:0];
            ll_next[i]  = mag_reg[i][LW-1:0] * mag_reg[i][LW-1:0];
            sq_next[i]  = (SQW'(hh_reg[i]) << (2 * LW)) + (SQW'(hl_reg[i]) << (LW + 1))
                        + SQW'(ll_reg[i]);
        end
        s_next = SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);
        // 255^2 = 2^16 - 2^9 + 1
        r_next = (RW'(sq_reg[2]) << ffs_pkg::SQ_HI_SHIFT)
               - (RW'(sq_reg[2]) << ffs_pkg::SQ_LO_SHIFT) + RW'(sq_reg[2]);
    end

    always_comb
    begin
        ctl_next[1] = '{valid: start, active: 1'b0, deg: 1'b0};
        for (int i = 2; i <= 7; i++)
        begin
            ctl_next[i] = ctl_reg[i-1];
        end
        ctl_next[4].deg    = (cross_reg[0] == '0) && (cross_reg[1] == '0)
                           && (cross_reg[2] == '0);
        ctl_next[4].active = cross_reg[2][NW-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= 7; i++)
            begin
                ctl_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 1; i <= 7; i++)
            begin
                ctl_reg[i] <= ctl_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        edge_reg  <= edge_next;
        prod_reg  <= prod_next;
        cross_reg <= cross_next;
        mag_reg   <= mag_next;
        hh_reg    <= hh_next;
        hl_reg    <= hl_next;
        ll_reg    <= ll_next;
        sq_reg    <= sq_next;
        s_reg     <= s_next;
        r_reg     <= r_next;
    end

    // gray bit search, msb first
    assign ctl_chain[0] = ctl_reg[7];
    assign g_chain[0]   = '0;
    assign p_chain[0]   = '0;
    assign q_chain[0]   = '0;
    assign s_chain[0]   = s_reg;
    assign r_chain[0]   = r_reg;

    for (genvar k = 0; k < NS; k++)
    begin : g_step
        ffs_step #(
            .SW  (SW),
            .BIT (NS - 1 - k)
        ) u_step (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl_in  (ctl_chain[k]),
            .g_in    (g_chain[k]),
            .p_in    (p_chain[k]),
            .q_in    (q_chain[k]),
            .s_in    (s_chain[k]),
            .r_in    (r_chain[k]),
            .ctl_out (ctl_chain[k+1]),
            .g_out   (g_chain[k+1]),
            .p_out   (p_chain[k+1]),
            .q_out   (q_chain[k+1]),
            .s_out   (s_chain[k+1]),
            .r_out   (r_chain[k+1])
        );
    end

    assign done       = ctl_chain[NS].valid;
    assign degenerate = ctl_chain[NS].deg;
    assign gray_level = g_chain[NS];
    assign face_color = {g_chain[NS], g_chain[NS], g_chain[NS], ffs_pkg::ALPHA_BYTE};

endmodule

// File: hw/rtl/ffs_step.sv
module ffs_step #(
    parameter int SW  = 102,
    parameter int BIT = 7
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ffs_pkg::ffs_ctl_t               ctl_in,
    input  logic [ffs_pkg::GRAY_BITS-1:0]   g_in,
    input  logic [SW+ffs_pkg::GRAY_BITS-1:0]    p_in,
    input  logic [SW+ffs_pkg::GRAY_SQ_BITS-1:0] q_in,
    input  logic [SW-1:0]                   s_in,
    input  logic [SW+ffs_pkg::GRAY_SQ_BITS-3:0] r_in,
    output ffs_pkg::ffs_ctl_t               ctl_out,
    output logic [ffs_pkg::GRAY_BITS-1:0]   g_out,
    output logic [SW+ffs_pkg::GRAY_BITS-1:0]    p_out,
    output logic [SW+ffs_pkg::GRAY_SQ_BITS-1:0] q_out,
    output logic [SW-1:0]                   s_out,
    output logic [SW+ffs_pkg::GRAY_SQ_BITS-3:0] r_out
);

    localparam int PW       = SW + ffs_pkg::GRAY_BITS;
    localparam int QW       = SW + ffs_pkg::GRAY_SQ_BITS;
    localparam int RW       = SW + ffs_pkg::GRAY_SQ_BITS - 2;
    localparam int MASK_INT = 1 << BIT;
    localparam logic [ffs_pkg::GRAY_BITS-1:0] BIT_MASK = MASK_INT[ffs_pkg::GRAY_BITS-1:0];

    ffs_pkg::ffs_ctl_t              ctl_reg;
    logic [ffs_pkg::GRAY_BITS-1:0]  g_reg, g_next;
    logic [PW-1:0]                  p_reg, p_next;
    logic [QW-1:0]                  q_reg, q_next;
    logic [SW-1:0]                  s_reg;
    logic [RW-1:0]                  r_reg;
    logic [QW-1:0]                  cand_q;
    logic                           take;

    // (g + b)^2 s = g^2 s + 2 b g s + b^2 s, with b a power of two
    always_comb
    begin
        cand_q = q_in + (QW'(p_in) << (BIT + 1)) + (QW'(s_in) << (2 * BIT));
        take   = ctl_in.active && (cand_q <= QW'(r_in));
        g_next = take ? (g_in | BIT_MASK) : g_in;
        p_next = take ? (p_in + (PW'(s_in) << BIT)) : p_in;
        q_next = take ? cand_q : q_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        g_reg <= g_next;
        p_reg <= p_next;
        q_reg <= q_next;
        s_reg <= s_in;
        r_reg <= r_in;
    end

    assign ctl_out = ctl_reg;
    assign g_out   = g_reg;
    assign p_out   = p_reg;
    assign q_out   = q_reg;
    assign s_out   = s_reg;
    assign r_out   = r_reg;

endmodule

// File: hw/rtl/ffs_checker.sv
module ffs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [7:0]  gray_level,
    input logic [31:0] face_color,
    input logic        degenerate
);

    localparam int LATENCY = 15;

    a_never_busy : assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    a_result_follows_request : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without matching request");

    a_color_packing : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (face_color[7:0] == ffs_pkg::ALPHA_BYTE) && (face_color[15:8] == gray_level)
                 && (face_color[23:16] == gray_level) && (face_color[31:24] == gray_level))
        else $error("color word does not match gray level");

    a_degenerate_dark : assert property (@(posedge clk) disable iff (!rst_n)
        (done && degenerate) |-> (gray_level == '0))
        else $error("degenerate face not dark");

endmodule

bind flat_face_shading ffs_checker u_ffs_checker (.*);

// File: bench/flat_face_shading_tb.sv
`timescale 1ns / 1ps

module flat_face_shading_tb;

    localparam int COORD_BITS = 24;
    localparam int CMAX = 8388607;
    localparam int CMIN = -8388608;
    localparam int RANDOM_FACES = 1800;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT = 200000;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t v0x, v0y, v0z;
        coord_t v1x, v1y, v1z;
        coord_t v2x, v2y, v2z;
    } face_t;

    typedef struct packed {
        logic [ffs_pkg::GRAY_BITS-1:0] gray;
        logic [31:0]                   color;
        logic                          deg;
    } shade_t;

    typedef struct packed {
        face_t  corners;
        logic   typed;
        shade_t want;
    } row_t;

    localparam shade_t DEGEN_SHADE = {8'd0, 24'd0, ffs_pkg::ALPHA_BYTE, 1'b1};
    localparam shade_t DARK_SHADE  = {8'd0, 24'd0, ffs_pkg::ALPHA_BYTE, 1'b0};
    localparam shade_t LIT_SHADE   = {8'hFF, 24'hFFFFFF, ffs_pkg::ALPHA_BYTE, 1'b0};

    logic   clk = 1'b0;
    logic   rst_n;
    logic   start;
    logic   busy;
    coord_t v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z;
    logic   done;
    logic [7:0]  gray_level;
    logic [31:0] face_color;
    logic        degenerate;

    shade_t shades_due[$];
    row_t   face_rows[$];
    shade_t oldest_shade;
    int     mismatches = 0;
    int     cycle_count = 0;

    flat_face_shading #(.COORD_BITS(COORD_BITS)) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .v0_x       (v0_x),
        .v0_y       (v0_y),
        .v0_z       (v0_z),
        .v1_x       (v1_x),
        .v1_y       (v1_y),
        .v1_z       (v1_z),
        .v2_x       (v2_x),
        .v2_y       (v2_y),
        .v2_z       (v2_z),
        .done       (done),
        .gray_level (gray_level),
        .face_color (face_color),
        .degenerate (degenerate)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic face_t make_face(int ax, int ay, int az, int bx, int by, int bz,
                                        int cx, int cy, int cz);
        face_t f;
        f.v0x = coord_t'(ax);
        f.v0y = coord_t'(ay);
        f.v0z = coord_t'(az);
        f.v1x = coord_t'(bx);
        f.v1y = coord_t'(by);
        f.v1z = coord_t'(bz);
        f.v2x = coord_t'(cx);
        f.v2y = coord_t'(cy);
        f.v2z = coord_t'(cz);
        return f;
    endfunction

    task automatic add_row(face_t f, logic typed, shade_t want);
        row_t row;
        row.corners = f;
        row.typed   = typed;
        row.want    = want;
        face_rows   = {face_rows, row};
    endtask

    // exact lambert gray: largest g with g*g*|n|^2 <= 65025*nz^2, zero if degenerate or nz >= 0
    function automatic shade_t shade_of(face_t f);
        longint ax, ay, az, bx, by, bz, nx, ny, nz;
        logic [127:0] sx, sy, sz, norm_sq, z_term;
        logic [7:0] g, trial;
        shade_t r;
        ax = longint'($signed(f.v1x)) - longint'($signed(f.v0x));
        ay = longint'($signed(f.v1y)) - longint'($signed(f.v0y));
        az = longint'($signed(f.v1z)) - longint'($signed(f.v0z));
        bx = longint'($signed(f.v2x)) - longint'($signed(f.v0x));
        by = longint'($signed(f.v2y)) - longint'($signed(f.v0y));
        bz = longint'($signed(f.v2z)) - longint'($signed(f.v0z));
        nx = ay * bz - az * by;
        ny = az * bx - ax * bz;
        nz = ax * by - ay * bx;
        sx = (nx < 0) ? -nx : nx;
        sy = (ny < 0) ? -ny : ny;
        sz = (nz < 0) ? -nz : nz;
        sx = sx * sx;
        sy = sy * sy;
        sz = sz * sz;
        norm_sq = sx + sy + sz;
        z_term = sz * 128'd65025;
        g = 8'd0;
        r.deg = (nx == 0 && ny == 0 && nz == 0);
        if (!r.deg && nz < 0)
        begin
            for (int b = 7; b >= 0; b--)
            begin
                trial = g | (8'd1 << b);
                if (norm_sq * trial * trial <= z_term)
                    g = trial;
            end
        end
        r.gray = g;
        r.color = {g, g, g, ffs_pkg::ALPHA_BYTE};
        return r;
    endfunction

    function automatic face_t random_face();
        int kind, ox, oy, oz, dx, dy, dz, k, x0, y0, z0;
        int pick[5];
        face_t f;
        kind = $urandom_range(99);
        x0 = int'(coord_t'($urandom));
        y0 = int'(coord_t'($urandom));
        z0 = int'(coord_t'($urandom));
        f = make_face(x0, y0, z0, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        if (kind < 45)
            return f;
        if (kind < 70)
        begin
            // small triangle around a random spot
            f = make_face(x0, y0, z0,
                          x0 + int'($urandom_range(512)) - 256,
                          y0 + int'($urandom_range(512)) - 256,
                          z0 + int'($urandom_range(512)) - 256,
                          x0 + int'($urandom_range(512)) - 256,
                          y0 + int'($urandom_range(512)) - 256,
                          z0 + int'($urandom_range(512)) - 256);
        end
        else if (kind < 80)
        begin
            // collinear vertices
            dx = int'($urandom_range(600)) - 300;
            dy = int'($urandom_range(600)) - 300;
            dz = int'($urandom_range(600)) - 300;
            k = int'($urandom_range(8)) - 4;
            ox = x0 / 4;
            oy = y0 / 4;
            oz = z0 / 4;
            f = make_face(ox, oy, oz, ox + dx, oy + dy, oz + dz,
                          ox + k * dx, oy + k * dy, oz + k * dz);
        end
        else if (kind < 90)
        begin
            // close to facing the light
            f = make_face(x0, y0, z0,
                          x0 + int'($urandom_range(2097152)) - 1048576,
                          y0 + int'($urandom_range(2097152)) - 1048576,
                          z0 + int'($urandom_range(2048)) - 1024,
                          x0 + int'($urandom_range(2097152)) - 1048576,
                          y0 + int'($urandom_range(2097152)) - 1048576,
                          z0 + int'($urandom_range(2048)) - 1024);
        end
        else
        begin
            pick = '{CMIN, CMAX, 0, -1, 1};
            f = make_face(pick[$urandom_range(4)], pick[$urandom_range(4)],
                          pick[$urandom_range(4)], pick[$urandom_range(4)],
                          pick[$urandom_range(4)], pick[$urandom_range(4)],
                          pick[$urandom_range(4)], pick[$urandom_range(4)],
                          pick[$urandom_range(4)]);
            if ($urandom_range(1))
            begin
                f.v2x = f.v0x;
                f.v2y = f.v0y;
                f.v2z = f.v0z;
            end
        end
        return f;
    endfunction

    // entered and left at a falling edge
    task automatic send_face(face_t f, logic typed, shade_t want, logic may_idle);
        shade_t due;
        while (may_idle && $urandom_range(99) < 32)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        v0_x <= f.v0x;
        v0_y <= f.v0y;
        v0_z <= f.v0z;
        v1_x <= f.v1x;
        v1_y <= f.v1y;
        v1_z <= f.v1z;
        v2_x <= f.v2x;
        v2_y <= f.v2y;
        v2_z <= f.v2z;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        due = typed ? want : shade_of(f);
        shades_due = {shades_due, due};
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (shades_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: gray %0d color %h deg %b",
                             gray_level, face_color, degenerate);
            end
            else
            begin
                oldest_shade = shades_due.pop_front();
                if (oldest_shade.gray !== gray_level || oldest_shade.color !== face_color
                    || oldest_shade.deg !== degenerate)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected gray %0d color %h deg %b, got %0d %h %b",
                                 oldest_shade.gray, oldest_shade.color, oldest_shade.deg,
                                 gray_level, face_color, degenerate);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        {v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z} = '0;

        // all vertices equal
        add_row(make_face(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, DEGEN_SHADE);
        add_row(make_face(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX),
                1'b1, DEGEN_SHADE);
        add_row(make_face(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN),
                1'b1, DEGEN_SHADE);
        // collinear across the full range, and a repeated vertex
        add_row(make_face(CMIN, CMIN, CMIN, 0, 0, 0, CMAX, CMAX, CMAX),
                1'b0, DEGEN_SHADE);
        add_row(make_face(7, -3, 9, 7, -3, 9, 100, 200, -300), 1'b1, DEGEN_SHADE);
        // facing away and head-on, unit and full-range edges
        add_row(make_face(0, 0, 0, 1, 0, 0, 0, 1, 0), 1'b1, DARK_SHADE);
        add_row(make_face(0, 0, 0, 0, 1, 0, 1, 0, 0), 1'b1, LIT_SHADE);
        add_row(make_face(CMIN, CMIN, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX),
                1'b1, LIT_SHADE);
        add_row(make_face(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX),
                1'b1, DARK_SHADE);
        add_row(make_face(-1, -1, -1, -1, 0, -1, 0, -1, -1), 1'b1, LIT_SHADE);
        // edge-on: normal lies in the screen plane
        add_row(make_face(5, 0, 0, 5, 1, 0, 5, 0, 1), 1'b1, DARK_SHADE);
        // tilted faces
        add_row(make_face(0, 0, 0, 0, 1, 0, 1, 0, 1), 1'b0, DARK_SHADE);
        add_row(make_face(0, 0, 0, 0, 1, 0, 1, 0, 1000), 1'b0, DARK_SHADE);
        add_row(make_face(0, 0, 0, 0, 1, 0, 1000, 0, 1), 1'b0, DARK_SHADE);
        add_row(make_face(CMIN, CMIN, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX),
                1'b0, DARK_SHADE);
        add_row(make_face(CMAX, CMAX, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN),
                1'b0, DARK_SHADE);
        add_row(make_face(24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA,
                          24'h555555, 24'hAAAAAA, 24'h555555, 24'h555555,
                          24'hAAAAAA), 1'b0, DARK_SHADE);
        add_row(make_face(24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555,
                          24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'hAAAAAA,
                          24'h555555), 1'b0, DARK_SHADE);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (face_rows[i])
            send_face(face_rows[i].corners, face_rows[i].typed, face_rows[i].want, 1'b1);

        for (int n = 0; n < RANDOM_FACES; n++)
        begin
            // let the pipeline run empty once
            if (n == 1000)
            begin
                start <= 1'b0;
                while (shades_due.size() != 0)
                    @(posedge clk);
                @(negedge clk);
            end
            send_face(random_face(), 1'b0, DARK_SHADE, !(n >= 500 && n < 800));
        end
        start <= 1'b0;

        while (shades_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
